// ===== rtl/png_scanline_unfilter_rgba8_unit_assert.svh =====
// Assertion macros for the scanline unfilter unit.
// Each macro expects signals named clock and reset in the calling scope.
`ifndef PNG_SCANLINE_UNFILTER_RGBA8_UNIT_ASSERT_SVH
`define PNG_SCANLINE_UNFILTER_RGBA8_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PNGUNF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PNGUNF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/pngunf_pkg.sv =====
`timescale 1ns / 1ps
package pngunf_pkg;

   typedef enum logic [2:0] {
      FILT_NONE  = 3'd0,
      FILT_SUB   = 3'd1,
      FILT_UP    = 3'd2,
      FILT_AVG   = 3'd3,
      FILT_PAETH = 3'd4
   } filter_type;

   localparam logic [7:0] FILTER_LAST = 8'd4;

   localparam logic CSR_IDX_WIDTH  = 1'b0;
   localparam logic CSR_IDX_HEIGHT = 1'b1;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   typedef struct packed {
      logic       is_err;
      filter_type filt;
      logic       left_ok;
      logic       up_ok;
      logic       done;
      logic [7:0] data;
   } slot_type;

   function automatic logic [7:0] paeth_pred(input logic [7:0] a,
                                             input logic [7:0] b,
                                             input logic [7:0] c);
      logic signed [9:0] da;
      logic signed [9:0] db;
      logic signed [9:0] dc;
      logic signed [9:0] pa;
      logic signed [9:0] pb;
      logic signed [9:0] pc;
      logic [7:0]        pick;
      da = $signed({2'b00, b}) - $signed({2'b00, c});
      db = $signed({2'b00, a}) - $signed({2'b00, c});
      dc = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
      pa = (da < 0) ? -da : da;
      pb = (db < 0) ? -db : db;
      pc = (dc < 0) ? -dc : dc;
      if (pa <= pb && pa <= pc) begin
         pick = a;
      end else if (pb <= pc) begin
         pick = b;
      end else begin
         pick = c;
      end
      return pick;
   endfunction

endpackage

// ===== rtl/pngunf_row_mem.sv =====
`timescale 1ns / 1ps
module pngunf_row_mem #(
   parameter int MAX_WIDTH_PIXELS = 4096,
   parameter int BYTES_PER_PIXEL  = 4,
   localparam int STORE_DEPTH = MAX_WIDTH_PIXELS * BYTES_PER_PIXEL,
   localparam int COL_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1
) (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [COL_W-1:0] rd_addr,
   output logic [7:0]       rd_data,
   input  logic             wr_en,
   input  logic [COL_W-1:0] wr_addr,
   input  logic [7:0]       wr_data
);

   logic [7:0] row_mem [STORE_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem[wr_addr] <= wr_data;
      end
   end

   // A read that meets a write to the same entry takes the new byte.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && wr_addr == rd_addr) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= row_mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/pngunf_ctrl.sv =====
`timescale 1ns / 1ps
module pngunf_ctrl #(
   parameter int MAX_WIDTH_PIXELS = 4096,
   parameter int BYTES_PER_PIXEL  = 4,
   localparam int STORE_DEPTH = MAX_WIDTH_PIXELS * BYTES_PER_PIXEL,
   localparam int COL_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1,
   localparam int LANE_W = (BYTES_PER_PIXEL > 1) ? $clog2(BYTES_PER_PIXEL) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [12:0]         width_cfg,
   input  logic [15:0]         height_cfg,
   input  logic                req_valid,
   input  logic [7:0]          req_data_byte,
   output logic                req_stall,
   input  logic                slot_free,
   output logic                slot_valid,
   output pngunf_pkg::slot_type slot,
   output logic [COL_W-1:0]    slot_col,
   output logic [LANE_W-1:0]   slot_lane,
   output logic                rd_en,
   output logic [COL_W-1:0]    rd_addr
);
   import pngunf_pkg::*;

   localparam int ROW_W  = $clog2(STORE_DEPTH + 1);
   localparam int WPIX_W = $clog2(MAX_WIDTH_PIXELS + 1);

   logic [COL_W-1:0]  col_ff, col_in;
   logic [LANE_W-1:0] lane_ff, lane_in;
   logic              left_ok_ff, left_ok_in;
   logic [15:0]       row_ff, row_in;
   filter_type        filt_ff, filt_in;
   logic              await_ff, await_in;
   logic              halted_ff, halted_in;
   logic              slot_valid_ff, slot_valid_in;
   slot_type          slot_ff, slot_in;
   logic [COL_W-1:0]  slot_col_ff, slot_col_in;
   logic [LANE_W-1:0] slot_lane_ff, slot_lane_in;

   logic              accept;
   logic [WPIX_W-1:0] wpix;
   logic [ROW_W-1:0]  row_bytes;
   logic [ROW_W-1:0]  col_next;
   logic              row_end;
   logic [15:0]       row_next;
   logic [15:0]       height_eff;
   logic              last_row;
   logic              lane_wrap;

   assign req_stall = !halted_ff && !slot_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (width_cfg == 13'd0) begin
         wpix = WPIX_W'(1);
      end else if (32'(width_cfg) > MAX_WIDTH_PIXELS) begin
         wpix = WPIX_W'(MAX_WIDTH_PIXELS);
      end else begin
         wpix = WPIX_W'(width_cfg);
      end
      row_bytes  = ROW_W'(wpix * BYTES_PER_PIXEL);
      col_next   = ROW_W'(col_ff) + ROW_W'(1);
      row_end    = col_next >= row_bytes;
      row_next   = row_ff + 16'd1;
      height_eff = (height_cfg == 16'd0) ? 16'd1 : height_cfg;
      last_row   = (row_next == 16'd0) || (row_next >= height_eff);
      lane_wrap  = lane_ff == LANE_W'(BYTES_PER_PIXEL - 1);
   end

   always_comb begin
      col_in        = col_ff;
      lane_in       = lane_ff;
      left_ok_in    = left_ok_ff;
      row_in        = row_ff;
      filt_in       = filt_ff;
      await_in      = await_ff;
      halted_in     = halted_ff;
      slot_valid_in = slot_free ? 1'b0 : slot_valid_ff;
      slot_in       = slot_ff;
      slot_col_in   = slot_col_ff;
      slot_lane_in  = slot_lane_ff;
      rd_en         = 1'b0;
      if (accept && !halted_ff) begin
         if (await_ff) begin
            if (req_data_byte > FILTER_LAST) begin
               halted_in      = 1'b1;
               slot_valid_in  = 1'b1;
               slot_in.is_err = 1'b1;
               slot_in.filt   = FILT_NONE;
               slot_in.left_ok = 1'b0;
               slot_in.up_ok  = 1'b0;
               slot_in.done   = 1'b0;
               slot_in.data   = 8'd0;
            end else begin
               filt_in    = filter_type'(req_data_byte[2:0]);
               await_in   = 1'b0;
               col_in     = '0;
               lane_in    = '0;
               left_ok_in = 1'b0;
            end
         end else begin
            slot_valid_in   = 1'b1;
            slot_in.is_err  = 1'b0;
            slot_in.filt    = filt_ff;
            slot_in.left_ok = left_ok_ff;
            slot_in.up_ok   = row_ff != 16'd0;
            slot_in.done    = row_end && last_row;
            slot_in.data    = req_data_byte;
            slot_col_in     = col_ff;
            slot_lane_in    = lane_ff;
            rd_en           = 1'b1;
            if (row_end) begin
               col_in     = '0;
               lane_in    = '0;
               left_ok_in = 1'b0;
               await_in   = 1'b1;
               row_in     = last_row ? 16'd0 : row_next;
            end else begin
               col_in = COL_W'(col_next);
               if (lane_wrap) begin
                  lane_in    = '0;
                  left_ok_in = 1'b1;
               end else begin
                  lane_in = lane_ff + LANE_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         lane_ff       <= '0;
         left_ok_ff    <= 1'b0;
         row_ff        <= 16'd0;
         filt_ff       <= FILT_NONE;
         await_ff      <= 1'b1;
         halted_ff     <= 1'b0;
         slot_valid_ff <= 1'b0;
      end else begin
         col_ff        <= col_in;
         lane_ff       <= lane_in;
         left_ok_ff    <= left_ok_in;
         row_ff        <= row_in;
         filt_ff       <= filt_in;
         await_ff      <= await_in;
         halted_ff     <= halted_in;
         slot_valid_ff <= slot_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff      <= slot_in;
      slot_col_ff  <= slot_col_in;
      slot_lane_ff <= slot_lane_in;
   end

   assign slot_valid = slot_valid_ff;
   assign slot       = slot_ff;
   assign slot_col   = slot_col_ff;
   assign slot_lane  = slot_lane_ff;
   assign rd_addr    = col_ff;

endmodule

// ===== rtl/pngunf_recon.sv =====
`timescale 1ns / 1ps
module pngunf_recon #(
   parameter int MAX_WIDTH_PIXELS = 4096,
   parameter int BYTES_PER_PIXEL  = 4,
   localparam int STORE_DEPTH = MAX_WIDTH_PIXELS * BYTES_PER_PIXEL,
   localparam int COL_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1,
   localparam int LANE_W = (BYTES_PER_PIXEL > 1) ? $clog2(BYTES_PER_PIXEL) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 slot_valid,
   input  pngunf_pkg::slot_type slot,
   input  logic [COL_W-1:0]     slot_col,
   input  logic [LANE_W-1:0]    slot_lane,
   input  logic [7:0]           rd_data,
   output logic                 slot_free,
   output logic                 wr_en,
   output logic [COL_W-1:0]     wr_addr,
   output logic [7:0]           wr_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_pixel_byte,
   output logic                 rsp_status,
   output logic                 rsp_image_done
);
   import pngunf_pkg::*;

   logic [7:0] left_ff   [BYTES_PER_PIXEL];
   logic [7:0] upleft_ff [BYTES_PER_PIXEL];
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] pixel_ff, pixel_in;
   logic       status_ff, status_in;
   logic       done_ff, done_in;

   logic       retire;
   logic [7:0] left;
   logic [7:0] up;
   logic [7:0] upleft;
   logic [8:0] avg_sum;
   logic [7:0] pred;
   logic [7:0] res;

   assign slot_free = !slot_valid || !rsp_valid_ff || !rsp_stall;
   assign retire    = slot_valid && slot_free;

   always_comb begin
      up      = slot.up_ok ? rd_data : 8'd0;
      left    = slot.left_ok ? left_ff[slot_lane] : 8'd0;
      upleft  = (slot.up_ok && slot.left_ok) ? upleft_ff[slot_lane] : 8'd0;
      avg_sum = {1'b0, left} + {1'b0, up};
      case (slot.filt)
         FILT_SUB:   pred = left;
         FILT_UP:    pred = up;
         FILT_AVG:   pred = avg_sum[8:1];
         FILT_PAETH: pred = paeth_pred(left, up, upleft);
         default:    pred = 8'd0;
      endcase
      res = slot.data + pred;
   end

   assign wr_en   = retire && !slot.is_err;
   assign wr_addr = slot_col;
   assign wr_data = res;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         left_ff[slot_lane]   <= res;
         upleft_ff[slot_lane] <= up;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      pixel_in     = pixel_ff;
      status_in    = status_ff;
      done_in      = done_ff;
      if (retire) begin
         rsp_valid_in = 1'b1;
         pixel_in     = slot.is_err ? 8'd0 : res;
         status_in    = slot.is_err ? STATUS_ERR : STATUS_OK;
         done_in      = slot.done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pixel_ff  <= pixel_in;
      status_ff <= status_in;
      done_ff   <= done_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_byte = pixel_ff;
   assign rsp_status     = status_ff;
   assign rsp_image_done = done_ff;

endmodule

// ===== rtl/png_scanline_unfilter_rgba8_unit.sv =====
`timescale 1ns / 1ps
// Each result passes the slot register and then the response register.
// Throughput: one byte per cycle while req_stall is low; the row store read is
// issued at accept; predictor, add and write-back close when the slot retires.
// Filter type bytes give no result unless invalid.
// Reset clears the control state; the row store is not cleared.
`include "png_scanline_unfilter_rgba8_unit_assert.svh"
module png_scanline_unfilter_rgba8_unit #(
   parameter int MAX_WIDTH_PIXELS = 4096,
   parameter int BYTES_PER_PIXEL  = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_pixel_byte,
   output logic        rsp_status,
   output logic        rsp_image_done
);
   import pngunf_pkg::*;

   localparam int STORE_DEPTH = MAX_WIDTH_PIXELS * BYTES_PER_PIXEL;
   localparam int COL_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int LANE_W = (BYTES_PER_PIXEL > 1) ? $clog2(BYTES_PER_PIXEL) : 1;

   logic [12:0]       width_ff, width_in;
   logic [15:0]       height_ff, height_in;

   logic              slot_valid;
   slot_type          slot;
   logic [COL_W-1:0]  slot_col;
   logic [LANE_W-1:0] slot_lane;
   logic              slot_free;
   logic              mem_rd_en;
   logic [COL_W-1:0]  mem_rd_addr;
   logic [7:0]        mem_rd_data;
   logic              mem_wr_en;
   logic [COL_W-1:0]  mem_wr_addr;
   logic [7:0]        mem_wr_data;

   assign csr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_IDX_WIDTH:  width_in  = csr_data[12:0];
            CSR_IDX_HEIGHT: height_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 13'd1;
         height_ff <= 16'd1;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   pngunf_ctrl #(
      .MAX_WIDTH_PIXELS(MAX_WIDTH_PIXELS),
      .BYTES_PER_PIXEL (BYTES_PER_PIXEL)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .width_cfg    (width_ff),
      .height_cfg   (height_ff),
      .req_valid    (req_valid),
      .req_data_byte(req_data_byte),
      .req_stall    (req_stall),
      .slot_free    (slot_free),
      .slot_valid   (slot_valid),
      .slot         (slot),
      .slot_col     (slot_col),
      .slot_lane    (slot_lane),
      .rd_en        (mem_rd_en),
      .rd_addr      (mem_rd_addr)
   );

   pngunf_row_mem #(
      .MAX_WIDTH_PIXELS(MAX_WIDTH_PIXELS),
      .BYTES_PER_PIXEL (BYTES_PER_PIXEL)
   ) u_row_mem (
      .clock  (clock),
      .rd_en  (mem_rd_en),
      .rd_addr(mem_rd_addr),
      .rd_data(mem_rd_data),
      .wr_en  (mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data)
   );

   pngunf_recon #(
      .MAX_WIDTH_PIXELS(MAX_WIDTH_PIXELS),
      .BYTES_PER_PIXEL (BYTES_PER_PIXEL)
   ) u_recon (
      .clock         (clock),
      .reset         (reset),
      .slot_valid    (slot_valid),
      .slot          (slot),
      .slot_col      (slot_col),
      .slot_lane     (slot_lane),
      .rd_data       (mem_rd_data),
      .slot_free     (slot_free),
      .wr_en         (mem_wr_en),
      .wr_addr       (mem_wr_addr),
      .wr_data       (mem_wr_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_pixel_byte(rsp_pixel_byte),
      .rsp_status    (rsp_status),
      .rsp_image_done(rsp_image_done)
   );

   `PNGUNF_ASSERT_NOW(a_err_payload, rsp_valid && rsp_status, rsp_pixel_byte == 8'd0 && !rsp_image_done, "error transaction carries pixel data")
   `PNGUNF_ASSERT_NEXT(a_err_last, rsp_valid && rsp_status && !rsp_stall, !rsp_valid, "transaction after error")
   `PNGUNF_ASSERT_NOW(a_no_write_stalled, slot_valid && rsp_valid && rsp_stall, !mem_wr_en, "row store written while output stalled")

endmodule
